// ===== rtl/tclr_pkg.sv =====
// ----------------------------------------------------------------------------
// Text command line recogniser package
// Shared sizes, status and command codes, control structs and the fixed
// command vocabulary used by the controller and the datapath.
// ----------------------------------------------------------------------------
package tclr_pkg;

    // Line store geometry.
    localparam int LINE_CAPACITY = 32;
    localparam int ADDR_W        = $clog2(LINE_CAPACITY);
    localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);

    // Vocabulary geometry.
    localparam int VOCAB_COUNT  = 7;
    localparam int MAX_WORD_LEN = 13;

    // Special characters.
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Parse status codes.
    localparam logic [2:0] ST_PROGRESS = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_INVALID  = 3'd3;
    localparam logic [2:0] ST_READY    = 3'd4;

    // Command codes.
    localparam logic [2:0] CMD_LED_ON      = 3'd0;
    localparam logic [2:0] CMD_LED_OFF     = 3'd1;
    localparam logic [2:0] CMD_LED_TOGGLE  = 3'd2;
    localparam logic [2:0] CMD_CLEAR_WARN  = 3'd3;
    localparam logic [2:0] CMD_RESET       = 3'd4;
    localparam logic [2:0] CMD_FORCE_FAULT = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       append;
        logic       clear_len;
        logic       walk_start;
        logic       walk_step;
        logic       out_load;
        logic       use_match;
        logic [2:0] status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_cr;
        logic is_lf;
        logic len_zero;
        logic len_full;
        logic walk_last;
        logic out_free;
    } t_dp_stat;

    // Vocabulary text, first character in the top byte, zero padded.
    function automatic logic [8*MAX_WORD_LEN-1:0] word_text(input logic [2:0] k);
        logic [8*MAX_WORD_LEN-1:0] text;
        text = '0;
        case (k)
            3'd0:    text = {"LED ON", {7{8'h00}}};
            3'd1:    text = {"LED OFF", {6{8'h00}}};
            3'd2:    text = {"LED TOGGLE", {3{8'h00}}};
            3'd3:    text = "CLEAR WARNING";
            3'd4:    text = {"RESET", {8{8'h00}}};
            3'd5:    text = {"FAULT", {8{8'h00}}};
            3'd6:    text = {"FORCE FAULT", {2{8'h00}}};
            default: text = '0;
        endcase
        return text;
    endfunction

    // Length of each vocabulary word.
    function automatic logic [LEN_W-1:0] word_len(input logic [2:0] k);
        logic [LEN_W-1:0] len;
        len = '0;
        case (k)
            3'd0:    len = LEN_W'(6);
            3'd1:    len = LEN_W'(7);
            3'd2:    len = LEN_W'(10);
            3'd3:    len = LEN_W'(13);
            3'd4:    len = LEN_W'(5);
            3'd5:    len = LEN_W'(5);
            3'd6:    len = LEN_W'(11);
            default: len = '0;
        endcase
        return len;
    endfunction

    // Command code of each vocabulary word.
    function automatic logic [2:0] word_code(input logic [2:0] k);
        logic [2:0] code;
        code = CMD_LED_ON;
        case (k)
            3'd0:    code = CMD_LED_ON;
            3'd1:    code = CMD_LED_OFF;
            3'd2:    code = CMD_LED_TOGGLE;
            3'd3:    code = CMD_CLEAR_WARN;
            3'd4:    code = CMD_RESET;
            3'd5:    code = CMD_FORCE_FAULT;
            3'd6:    code = CMD_FORCE_FAULT;
            default: code = CMD_LED_ON;
        endcase
        return code;
    endfunction

    // Character at position i of vocabulary word k; zero past the longest word.
    function automatic logic [7:0] word_char(input logic [2:0] k,
                                             input logic [ADDR_W-1:0] i);
        logic [8*MAX_WORD_LEN-1:0] text;
        logic [7:0]                ch;
        text = word_text(k);
        ch   = 8'h00;
        for (int p = 0; p < MAX_WORD_LEN; p++) begin
            if (i == ADDR_W'(p)) begin
                ch = text[8*(MAX_WORD_LEN-1-p) +: 8];
            end
        end
        return ch;
    endfunction

endpackage

// ===== rtl/tclr_datapath.sv =====
// ----------------------------------------------------------------------------
// Text command line recogniser datapath
// Holds the line store, the line length, the compare walk and the result
// register. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module tclr_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_rx_byte,
    input  tclr_pkg::t_dp_cmd   i_cmd,
    output tclr_pkg::t_dp_stat  o_stat,
    input  logic                i_res_stall,
    output logic                o_res_valid,
    output logic [2:0]          o_parse_status,
    output logic [2:0]          o_command_code
);

    logic [7:0]                          r_line_store [tclr_pkg::LINE_CAPACITY];
    logic [tclr_pkg::LEN_W-1:0]          r_len;
    logic [tclr_pkg::LEN_W-1:0]          n_len;
    logic [tclr_pkg::ADDR_W-1:0]         r_idx;
    logic [tclr_pkg::ADDR_W-1:0]         r_rd_idx;
    logic [7:0]                          r_rd_data;
    logic                                r_rd_vld;
    logic [tclr_pkg::VOCAB_COUNT-1:0]    r_match;
    logic [tclr_pkg::VOCAB_COUNT-1:0]    n_match;
    logic [tclr_pkg::VOCAB_COUNT-1:0]    hit;
    logic                                hit_any;
    logic [2:0]                          hit_code;
    logic [7:0]                          wr_byte;
    logic                                r_out_valid;
    logic [2:0]                          r_status;
    logic [2:0]                          r_code;

    // Byte classification and upper-casing of the incoming item.
    always_comb begin
        wr_byte = i_rx_byte;
        if (i_rx_byte inside {[tclr_pkg::CHAR_LOWER_A:tclr_pkg::CHAR_LOWER_Z]}) begin
            wr_byte = i_rx_byte - tclr_pkg::CASE_OFFSET;
        end
    end

    // Status towards the controller.
    always_comb begin
        o_stat.is_cr     = (i_rx_byte == tclr_pkg::CHAR_CR);
        o_stat.is_lf     = (i_rx_byte == tclr_pkg::CHAR_LF);
        o_stat.len_zero  = (r_len == '0);
        o_stat.len_full  = (r_len == tclr_pkg::LEN_W'(tclr_pkg::LINE_CAPACITY));
        o_stat.walk_last = (r_idx == tclr_pkg::ADDR_W'(tclr_pkg::MAX_WORD_LEN - 1))
                        || (tclr_pkg::LEN_W'(r_idx) + tclr_pkg::LEN_W'(1) == r_len);
        o_stat.out_free  = !r_out_valid || !i_res_stall;
    end

    // Line store: one write port for appending, one read port for the walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_line_store[r_len[tclr_pkg::ADDR_W-1:0]] <= wr_byte;
        end
        r_rd_data <= r_line_store[r_idx];
    end

    // Line length.
    always_comb begin
        n_len = r_len;
        if (i_cmd.clear_len) begin
            n_len = '0;
        end else if (i_cmd.append) begin
            n_len = r_len + tclr_pkg::LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
    end

    // Per-word match flags: a word survives while each stored character
    // equals its own character at that position.
    always_comb begin
        n_match = r_match;
        if (i_cmd.walk_start) begin
            n_match = '1;
        end else if (r_rd_vld) begin
            for (int k = 0; k < tclr_pkg::VOCAB_COUNT; k++) begin
                if (tclr_pkg::LEN_W'(r_rd_idx) >= tclr_pkg::word_len(3'(k))
                    || r_rd_data != tclr_pkg::word_char(3'(k), r_rd_idx)) begin
                    n_match[k] = 1'b0;
                end
            end
        end
    end

    // Walk address and pipeline of the read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.walk_start) begin
                r_idx <= '0;
            end else if (i_cmd.walk_step) begin
                r_idx <= r_idx + tclr_pkg::ADDR_W'(1);
            end
            r_rd_vld <= i_cmd.walk_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        r_match  <= n_match;
    end

    // A word matches only when the whole line has its length.
    always_comb begin
        hit_code = tclr_pkg::CMD_LED_ON;
        for (int k = 0; k < tclr_pkg::VOCAB_COUNT; k++) begin
            hit[k] = r_match[k] && (r_len == tclr_pkg::word_len(3'(k)));
        end
        hit_any = |hit;
        for (int k = tclr_pkg::VOCAB_COUNT - 1; k >= 0; k--) begin
            if (hit[k]) begin
                hit_code = tclr_pkg::word_code(3'(k));
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.use_match) begin
                r_status <= hit_any ? tclr_pkg::ST_READY : tclr_pkg::ST_INVALID;
                r_code   <= hit_any ? hit_code : tclr_pkg::CMD_LED_ON;
            end else begin
                r_status <= i_cmd.status;
                r_code   <= tclr_pkg::CMD_LED_ON;
            end
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_parse_status = r_status;
    assign o_command_code = r_code;

    // The line length never exceeds the store.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= tclr_pkg::LEN_W'(tclr_pkg::LINE_CAPACITY))
        else $error("line length beyond capacity");

    // Nothing is appended to a full line.
    a_no_append_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> !o_stat.len_full)
        else $error("append to a full line");

    // A result is never loaded over one that is still waiting.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> o_stat.out_free)
        else $error("result overwritten while stalled");

    // The command code is zero unless a command is ready.
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != tclr_pkg::ST_READY) |-> r_code == tclr_pkg::CMD_LED_ON)
        else $error("command code set without a ready command");

endmodule

// ===== rtl/tclr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text command line recogniser controller
// State machine that accepts items, sequences the line-end compare walk and
// issues commands to the datapath.
// ----------------------------------------------------------------------------
module tclr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rx_valid,
    output logic                o_rx_stall,
    input  tclr_pkg::t_dp_stat  i_stat,
    output tclr_pkg::t_dp_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    // Items are taken only in idle and when the result register can take one.
    assign o_rx_stall = !(r_state == S_IDLE && i_stat.out_free);
    assign accept     = i_rx_valid && !o_rx_stall;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_stat.is_cr) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.status   = tclr_pkg::ST_PROGRESS;
                    end else if (i_stat.is_lf) begin
                        if (i_stat.len_zero) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.status   = tclr_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.walk_start = 1'b1;
                            n_state          = S_WALK;
                        end
                    end else if (i_stat.len_full) begin
                        o_cmd.clear_len = 1'b1;
                        o_cmd.out_load  = 1'b1;
                        o_cmd.status    = tclr_pkg::ST_OVERFLOW;
                    end else begin
                        o_cmd.append   = 1'b1;
                        o_cmd.out_load = 1'b1;
                        o_cmd.status   = tclr_pkg::ST_PROGRESS;
                    end
                end
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.use_match = 1'b1;
                    o_cmd.clear_len = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A line end on a non-empty line starts the walk.
    a_lf_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_stat.is_lf && !i_stat.len_zero) |=> r_state == S_WALK)
        else $error("line end did not start the compare walk");

    // The drain cycle always follows the last walk step.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> $past(r_state) == S_WALK)
        else $error("drain entered outside a walk");

endmodule

// ===== rtl/text_command_line_recognizer_top.sv =====
// ----------------------------------------------------------------------------
// Text command line recogniser top level
// Gives one parse status per received byte and a command code when a line
// matches the fixed command vocabulary.
//
//   Channel   Direction  Handshake                Payload
//   rx        in         i_rx_valid / o_rx_stall  i_rx_byte[7:0]
//   res       out        o_res_valid / i_res_stall o_parse_status[2:0],
//                                                  o_command_code[2:0]
//
// Carriage return, ordinary bytes, overflow and empty lines are answered from idle.
// A line end on a non-empty line walks min(length, 13) characters: the line
// store is walked one character a cycle through its single read port.
// Reset is synchronous and clears the line length; store contents stay
// undefined until written. While a result is stalled the input is stalled
// too; the result register holds its item until it is taken.
// ----------------------------------------------------------------------------
module text_command_line_recognizer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [2:0] o_parse_status,
    output logic [2:0] o_command_code
);

    tclr_pkg::t_dp_cmd  cmd;
    tclr_pkg::t_dp_stat stat;

    // Control.
    tclr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Storage and compare.
    tclr_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (i_rx_byte),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_res_stall    (i_res_stall),
        .o_res_valid    (o_res_valid),
        .o_parse_status (o_parse_status),
        .o_command_code (o_command_code)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text command line recogniser testbench
// Feeds received bytes to the recogniser and checks the status item that each
// byte produces. A line-level model of the store predicts every status and
// command code. Stimulus opens with a short directed pass over the special
// bytes, then runs mostly well-formed command lines in mixed case, with
// damaged commands, noise, raw bytes and overlong lines mixed in. Both
// channels idle at random, apart from one calm stretch.
// ----------------------------------------------------------------------------
module tb;

    localparam int ITEM_TARGET   = 1100;
    localparam int CALM_FIRST    = 500;
    localparam int CALM_LAST     = 700;
    localparam int IDLE_PERCENT  = 11;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 40;

    // One expected status item.
    typedef struct {
        logic [2:0] status;
        logic [2:0] code;
    } t_line_status;

    // Line model and queue of expected status items.
    class t_line_status_board;
        string        phrases[7];
        logic [2:0]   phrase_codes[7];
        logic [7:0]   line_chars[tclr_pkg::LINE_CAPACITY];
        int unsigned  line_len;
        t_line_status pending_status[$];
        int           mismatches;

        function new();
            phrases      = '{"LED ON", "LED OFF", "LED TOGGLE", "CLEAR WARNING",
                             "RESET", "FAULT", "FORCE FAULT"};
            phrase_codes = '{tclr_pkg::CMD_LED_ON, tclr_pkg::CMD_LED_OFF,
                             tclr_pkg::CMD_LED_TOGGLE, tclr_pkg::CMD_CLEAR_WARN,
                             tclr_pkg::CMD_RESET, tclr_pkg::CMD_FORCE_FAULT,
                             tclr_pkg::CMD_FORCE_FAULT};
            line_len     = 0;
            mismatches   = 0;
        endfunction

        // Whole-line exact comparison against one command phrase.
        function bit line_is(string word);
            bit same;
            same = (line_len == word.len());
            for (int i = 0; same && i < word.len(); i++) begin
                if (line_chars[i] != 8'(word[i])) begin
                    same = 1'b0;
                end
            end
            return same;
        endfunction

        // Predicts the status of an accepted byte and updates the line.
        function void note_byte(logic [7:0] rx);
            t_line_status r;
            logic [7:0]   ch;
            bit           found;
            r.status = tclr_pkg::ST_PROGRESS;
            r.code   = tclr_pkg::CMD_LED_ON;
            found    = 1'b0;
            if (rx == tclr_pkg::CHAR_LF) begin
                if (line_len == 0) begin
                    r.status = tclr_pkg::ST_EMPTY;
                end else begin
                    r.status = tclr_pkg::ST_INVALID;
                    for (int k = 0; k < 7; k++) begin
                        if (!found && line_is(phrases[k])) begin
                            found    = 1'b1;
                            r.status = tclr_pkg::ST_READY;
                            r.code   = phrase_codes[k];
                        end
                    end
                    line_len = 0;
                end
            end else if (rx != tclr_pkg::CHAR_CR) begin
                if (line_len >= tclr_pkg::LINE_CAPACITY) begin
                    line_len = 0;
                    r.status = tclr_pkg::ST_OVERFLOW;
                end else begin
                    ch = rx;
                    if (ch inside {[tclr_pkg::CHAR_LOWER_A:tclr_pkg::CHAR_LOWER_Z]}) begin
                        ch = ch - tclr_pkg::CASE_OFFSET;
                    end
                    line_chars[line_len] = ch;
                    line_len++;
                end
            end
            pending_status.push_back(r);
        endfunction

        function void report(string msg);
            mismatches++;
            $error("%s", msg);
        endfunction

        // Compares an accepted result item with the oldest expectation.
        function void check_result(logic [2:0] status, logic [2:0] code);
            t_line_status want;
            if (pending_status.size() == 0) begin
                report($sformatf("unexpected result: parse_status %0d, command_code %0d",
                                 status, code));
            end else begin
                want = pending_status.pop_front();
                if (status !== want.status) begin
                    report($sformatf("parse_status mismatch: expected %0d, got %0d",
                                     want.status, status));
                end
                if (code !== want.code) begin
                    report($sformatf("command_code mismatch: expected %0d, got %0d",
                                     want.code, code));
                end
            end
        endfunction

        // Counts expectations that never arrived and returns the failure total.
        function int close_out();
            if (pending_status.size() != 0) begin
                report($sformatf("%0d expected results never arrived",
                                 pending_status.size()));
            end
            return mismatches;
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_rx_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_res_stall = 1'b0;
    logic       o_rx_stall;
    logic       o_res_valid;
    logic [2:0] o_parse_status;
    logic [2:0] o_command_code;

    t_line_status_board board = new();
    int                 items_sent = 0;
    bit                 calm = 1'b0;

    text_command_line_recognizer_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_parse_status (o_parse_status),
        .o_command_code (o_command_code)
    );

    // Clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side stalls at random, except in the calm stretch.
    always @(negedge i_clk) begin
        i_res_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Accepted result items go to the checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            board.check_result(o_parse_status, o_command_code);
        end
    end

    // Sends one byte; called at a falling edge and returns at a falling edge.
    task automatic send_byte(input logic [7:0] rx);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_rx_valid = 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid = 1'b1;
        i_rx_byte  = rx;
        @(posedge i_clk);
        while (o_rx_stall) begin
            @(posedge i_clk);
        end
        board.note_byte(rx);
        items_sent++;
        calm = (items_sent >= CALM_FIRST && items_sent < CALM_LAST);
        @(negedge i_clk);
    endtask

    // Sends a string, optionally lowering the case of random letters.
    task automatic send_text(input string s, input bit mixed);
        logic [7:0] ch;
        for (int i = 0; i < s.len(); i++) begin
            ch = s[i];
            if (mixed && ch inside {["A":"Z"]} && $urandom_range(0, 1)) begin
                ch = ch + tclr_pkg::CASE_OFFSET;
            end
            send_byte(ch);
        end
    endtask

    // Random byte that does not end the line.
    function automatic logic [7:0] line_byte();
        logic [7:0] ch;
        ch = 8'($urandom_range(0, 255));
        if (ch == tclr_pkg::CHAR_LF) begin
            ch = "X";
        end
        return ch;
    endfunction

    // Stimulus and end of run.
    initial begin
        int    pick;
        int    waited;
        int    n;
        string word;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: mixed case with a carriage return, empty lines, a lone
        // carriage return, boundary bytes forming an invalid line, a plain command.
        send_text("Reset", 1'b0);
        send_byte(tclr_pkg::CHAR_CR);
        send_byte(tclr_pkg::CHAR_LF);
        send_byte(tclr_pkg::CHAR_LF);
        send_byte(tclr_pkg::CHAR_CR);
        send_byte(tclr_pkg::CHAR_LF);
        send_byte(tclr_pkg::CHAR_CR);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h60);
        send_byte(8'h7B);
        send_byte(8'h61);
        send_byte(8'h7A);
        send_byte(tclr_pkg::CHAR_LF);
        send_text("FAULT", 1'b0);
        send_byte(tclr_pkg::CHAR_LF);

        // Random lines, mostly well-formed commands.
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            word = board.phrases[$urandom_range(0, 6)];
            if (pick < 60) begin
                send_text(word, 1'b1);
                if ($urandom_range(0, 3) == 0) begin
                    send_byte(tclr_pkg::CHAR_CR);
                end
                send_byte(tclr_pkg::CHAR_LF);
            end else if (pick < 75) begin
                // Damaged command: one character changed, cut short or extended.
                case ($urandom_range(0, 3))
                    0: begin
                        word[$urandom_range(0, word.len() - 1)] = 8'($urandom_range(32, 126));
                        send_text(word, 1'b1);
                    end
                    1: send_text(word.substr(0, word.len() - 2), 1'b1);
                    2: begin
                        send_text(word, 1'b1);
                        send_byte(line_byte());
                    end
                    default: begin
                        send_byte(" ");
                        send_text(word, 1'b1);
                    end
                endcase
                send_byte(tclr_pkg::CHAR_LF);
            end else if (pick < 85) begin
                n = $urandom_range(0, 20);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
                send_byte(tclr_pkg::CHAR_LF);
            end else if (pick < 93) begin
                // Nearly full, full or overlong line.
                n = $urandom_range(tclr_pkg::LINE_CAPACITY - 1, tclr_pkg::LINE_CAPACITY + 8);
                repeat (n) send_byte(line_byte());
                send_byte(tclr_pkg::CHAR_LF);
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
        end
        i_rx_valid = 1'b0;

        // Drain, then watch for stray results.
        waited = 0;
        while (board.pending_status.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (board.close_out() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
